>>> sv/ordered_array_list_unit_macros.svh
// ----------------------------------------------------------------------------
// Ordered array list unit - assertion macros
// Concurrent assertion shorthands shared by the RTL of the list unit.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_UNIT_MACROS_SVH
`define ORDERED_ARRAY_LIST_UNIT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define OAL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define OAL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/oal_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array list unit - package
// Defaults, action codes and the control store of the list sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;
    localparam int ACTION_W       = 3;
    localparam int POSITION_W     = 4;
    localparam int IN_ITEM_W      = 32;
    localparam int COUNT_OUT_W    = 5;
    localparam int STEP_W         = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_READ   = 3'd3,
        ACT_FIND   = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    // Control store addresses
    typedef enum logic [STEP_W-1:0] {
        S_IDLE       = 5'd0,
        S_INS_CHK    = 5'd1,
        S_INS_PRIME  = 5'd2,
        S_INS_SHIFT  = 5'd3,
        S_INS_WRITE  = 5'd4,
        S_UPD_CHK    = 5'd5,
        S_UPD_WRITE  = 5'd6,
        S_DEL_CHK    = 5'd7,
        S_DEL_PRIME  = 5'd8,
        S_DEL_SHIFT  = 5'd9,
        S_DEL_END    = 5'd10,
        S_RD_ADDR    = 5'd11,
        S_RD_CAP     = 5'd12,
        S_CLR        = 5'd13,
        S_FND_PRIME  = 5'd14,
        S_FND_CMP    = 5'd15,
        S_DONE       = 5'd16
    } t_step;

    typedef enum logic {
        SQ_BRANCH   = 1'b0,
        SQ_DISPATCH = 1'b1
    } t_seq;

    typedef enum logic [3:0] {
        C_NEVER    = 4'd0,
        C_ALWAYS   = 4'd1,
        C_FULL     = 4'd2,
        C_OOR      = 4'd3,
        C_APPEND   = 4'd4,
        C_INS_MORE = 4'd5,
        C_DEL_LAST = 4'd6,
        C_DEL_MORE = 4'd7,
        C_EMPTY    = 4'd8,
        C_FND_MORE = 4'd9
    } t_cond;

    typedef enum logic [3:0] {
        DP_NONE       = 4'd0,
        DP_LOAD       = 4'd1,
        DP_INS_PRIME  = 4'd2,
        DP_SHIFT_UP   = 4'd3,
        DP_INS_WRITE  = 4'd4,
        DP_UPD_WRITE  = 4'd5,
        DP_DEL_PRIME  = 4'd6,
        DP_SHIFT_DOWN = 4'd7,
        DP_DEL_END    = 4'd8,
        DP_RD_ADDR    = 4'd9,
        DP_RD_CAP     = 4'd10,
        DP_CLEAR      = 4'd11,
        DP_FND_PRIME  = 4'd12,
        DP_FND_CMP    = 4'd13,
        DP_EMIT       = 4'd14
    } t_op;

    typedef struct packed {
        t_seq  seq;
        t_cond cond;
        t_step target;
        t_op   op;
    } t_ctrl;

    // Control store: one word per step. The idle step dispatches on a new item;
    // elsewhere a taken branch goes to target, else the step counter advances by one.
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_IDLE, op: DP_NONE};
        unique case (step)
            S_IDLE:      w = '{seq: SQ_DISPATCH, cond: C_NEVER, target: S_IDLE,
                               op: DP_LOAD};
            S_INS_CHK:   w = '{seq: SQ_BRANCH, cond: C_FULL, target: S_DONE,
                               op: DP_NONE};
            S_INS_PRIME: w = '{seq: SQ_BRANCH, cond: C_APPEND, target: S_INS_WRITE,
                               op: DP_INS_PRIME};
            S_INS_SHIFT: w = '{seq: SQ_BRANCH, cond: C_INS_MORE, target: S_INS_SHIFT,
                               op: DP_SHIFT_UP};
            S_INS_WRITE: w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_DONE,
                               op: DP_INS_WRITE};
            S_UPD_CHK:   w = '{seq: SQ_BRANCH, cond: C_OOR, target: S_DONE,
                               op: DP_NONE};
            S_UPD_WRITE: w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_DONE,
                               op: DP_UPD_WRITE};
            S_DEL_CHK:   w = '{seq: SQ_BRANCH, cond: C_OOR, target: S_DONE,
                               op: DP_NONE};
            S_DEL_PRIME: w = '{seq: SQ_BRANCH, cond: C_DEL_LAST, target: S_DEL_END,
                               op: DP_DEL_PRIME};
            S_DEL_SHIFT: w = '{seq: SQ_BRANCH, cond: C_DEL_MORE, target: S_DEL_SHIFT,
                               op: DP_SHIFT_DOWN};
            S_DEL_END:   w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_DONE,
                               op: DP_DEL_END};
            S_RD_ADDR:   w = '{seq: SQ_BRANCH, cond: C_OOR, target: S_DONE,
                               op: DP_RD_ADDR};
            S_RD_CAP:    w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_DONE,
                               op: DP_RD_CAP};
            S_CLR:       w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_DONE,
                               op: DP_CLEAR};
            S_FND_PRIME: w = '{seq: SQ_BRANCH, cond: C_EMPTY, target: S_DONE,
                               op: DP_FND_PRIME};
            S_FND_CMP:   w = '{seq: SQ_BRANCH, cond: C_FND_MORE, target: S_FND_CMP,
                               op: DP_FND_CMP};
            S_DONE:      w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_IDLE,
                               op: DP_EMIT};
            default:     w = '{seq: SQ_BRANCH, cond: C_ALWAYS, target: S_IDLE,
                               op: DP_NONE};
        endcase
        return w;
    endfunction

    // Entry step of each action; unused codes go straight to the result.
    function automatic t_step dispatch(input logic [ACTION_W-1:0] action);
        t_step s;
        s = S_DONE;
        unique case (action)
            ACT_INSERT: s = S_INS_CHK;
            ACT_UPDATE: s = S_UPD_CHK;
            ACT_DELETE: s = S_DEL_CHK;
            ACT_READ:   s = S_RD_ADDR;
            ACT_FIND:   s = S_FND_PRIME;
            ACT_CLEAR:  s = S_CLR;
            default:    s = S_DONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/ordered_array_list_unit.sv
// ----------------------------------------------------------------------------
// Ordered array list unit
// Bounded ordered list in a RAM, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with i_action, i_position, i_at_end and
//   i_item; the item is taken at a clock edge where start is high and busy
//   is low. Actions: insert, update, delete, read, find, clear.
//   Result channel: o_done is high for exactly one cycle with o_ok,
//   o_item_out, o_found, o_found_position and o_entry_count valid in that
//   cycle. The receiver cannot hold results off; the block never waits.
//   A new item may be accepted in the very cycle its predecessor's result
//   is shown.
//   Cost per item: insert and delete grow with the entries moved, find
//   with the entries compared; the RAM's one read port and one write port
//   move or compare one entry per cycle. A new item is taken only once the
//   previous item's result is shown.
//   Reset clears the entry count, the step counter and the result strobe;
//   RAM contents are not cleared and are never used before being written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_array_list_unit_macros.svh"

module ordered_array_list_unit #(
    parameter int DEPTH      = oal_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = oal_pkg::ITEM_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [oal_pkg::ACTION_W-1:0]       i_action,
    input  wire logic [oal_pkg::POSITION_W-1:0]     i_position,
    input  wire logic                               i_at_end,
    input  wire logic [oal_pkg::IN_ITEM_W-1:0]      i_item,
    output logic                                    o_done,
    output logic                                    o_ok,
    output logic [oal_pkg::IN_ITEM_W-1:0]           o_item_out,
    output logic                                    o_found,
    output logic [oal_pkg::POSITION_W-1:0]          o_found_position,
    output logic [oal_pkg::COUNT_OUT_W-1:0]         o_entry_count
);

    // Address width, count width and a compare width with headroom for +2
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CW > oal_pkg::POSITION_W) ? CW : oal_pkg::POSITION_W) + 2;
    localparam int EXT_W = 64;

    // Sequencer state
    oal_pkg::t_step r_pc, n_pc;
    oal_pkg::t_ctrl ctrl;
    logic           cond_hit;

    // Control registers
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_done, n_done;

    // Datapath registers
    logic [oal_pkg::POSITION_W-1:0] r_pos, n_pos;
    logic [ITEM_WIDTH-1:0]          r_item, n_item;
    logic [AW-1:0]                  r_dst, n_dst;
    logic                           r_append, n_append;
    logic [AW-1:0]                  r_idx, n_idx;
    logic                           r_ok, n_ok;
    logic                           r_found, n_found;
    logic [AW-1:0]                  r_fpos, n_fpos;
    logic [ITEM_WIDTH-1:0]          r_item_out, n_item_out;

    // RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    // Widened views for compares and port widths
    logic [CMP_W-1:0]  cnt_x, idx_x, pos_x, ipos_x, fpos_x;
    logic [EXT_W-1:0]  item_in_x, item_out_x;
    logic [AW-1:0]     pos_a, ipos_a;
    logic              in_append;
    logic              match;

    assign cnt_x      = CMP_W'(r_cnt);
    assign idx_x      = CMP_W'(r_idx);
    assign pos_x      = CMP_W'(r_pos);
    assign ipos_x     = CMP_W'(i_position);
    assign fpos_x     = CMP_W'(r_fpos);
    assign pos_a      = pos_x[AW-1:0];
    assign ipos_a     = ipos_x[AW-1:0];
    assign item_in_x  = EXT_W'(i_item);
    assign item_out_x = EXT_W'(r_item_out);
    assign in_append  = i_at_end || (ipos_x >= cnt_x);
    assign match      = (ram_rdata == r_item);

    oal_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Fetch the control word of the current step
    assign ctrl = oal_pkg::ucode(r_pc);

    // Branch conditions, all from registered state
    always_comb begin
        cond_hit = 1'b0;
        unique case (ctrl.cond)
            oal_pkg::C_NEVER:    cond_hit = 1'b0;
            oal_pkg::C_ALWAYS:   cond_hit = 1'b1;
            oal_pkg::C_FULL:     cond_hit = (cnt_x == CMP_W'(DEPTH));
            oal_pkg::C_OOR:      cond_hit = (pos_x >= cnt_x);
            oal_pkg::C_APPEND:   cond_hit = r_append;
            oal_pkg::C_INS_MORE: cond_hit = ((r_idx - AW'(1)) > r_dst);
            oal_pkg::C_DEL_LAST: cond_hit = ((pos_x + CMP_W'(1)) == cnt_x);
            oal_pkg::C_DEL_MORE: cond_hit = ((idx_x + CMP_W'(2)) < cnt_x);
            oal_pkg::C_EMPTY:    cond_hit = (cnt_x == '0);
            oal_pkg::C_FND_MORE: cond_hit = !match && ((idx_x + CMP_W'(1)) < cnt_x);
            default:             cond_hit = 1'b0;
        endcase
    end

    // Step counter: dispatch on a new item, else branch or advance
    always_comb begin
        n_pc = r_pc;
        unique case (ctrl.seq)
            oal_pkg::SQ_DISPATCH: n_pc = start ? oal_pkg::dispatch(i_action) : r_pc;
            oal_pkg::SQ_BRANCH:   n_pc = cond_hit ? ctrl.target
                                                  : oal_pkg::t_step'(r_pc + 5'd1);
            default:              n_pc = oal_pkg::S_IDLE;
        endcase
    end

    // Datapath driven by the control word
    always_comb begin
        n_cnt      = r_cnt;
        n_done     = 1'b0;
        n_pos      = r_pos;
        n_item     = r_item;
        n_dst      = r_dst;
        n_append   = r_append;
        n_idx      = r_idx;
        n_ok       = r_ok;
        n_found    = r_found;
        n_fpos     = r_fpos;
        n_item_out = r_item_out;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = ram_rdata;
        ram_raddr  = r_idx;
        unique case (ctrl.op)
            oal_pkg::DP_NONE: begin
            end
            oal_pkg::DP_LOAD: begin
                // Latch the command and clear the result fields
                if (start) begin
                    n_pos      = i_position;
                    n_item     = item_in_x[ITEM_WIDTH-1:0];
                    n_append   = in_append;
                    n_dst      = in_append ? r_cnt[AW-1:0] : ipos_a;
                    n_ok       = 1'b0;
                    n_found    = 1'b0;
                    n_fpos     = '0;
                    n_item_out = '0;
                end
            end
            oal_pkg::DP_INS_PRIME: begin
                // Start at the free slot; fetch the last entry
                n_idx     = r_cnt[AW-1:0];
                ram_raddr = r_cnt[AW-1:0] - AW'(1);
            end
            oal_pkg::DP_SHIFT_UP: begin
                // Move entry idx-1 up to idx, fetch the one below
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                ram_raddr = r_idx - AW'(2);
                n_idx     = r_idx - AW'(1);
            end
            oal_pkg::DP_INS_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_item;
                n_cnt     = r_cnt + CW'(1);
                n_ok      = 1'b1;
            end
            oal_pkg::DP_UPD_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = pos_a;
                ram_wdata = r_item;
                n_ok      = 1'b1;
            end
            oal_pkg::DP_DEL_PRIME: begin
                n_idx     = pos_a;
                ram_raddr = pos_a + AW'(1);
            end
            oal_pkg::DP_SHIFT_DOWN: begin
                // Move entry idx+1 down to idx, fetch the one above
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                ram_raddr = r_idx + AW'(2);
                n_idx     = r_idx + AW'(1);
            end
            oal_pkg::DP_DEL_END: begin
                n_cnt = r_cnt - CW'(1);
                n_ok  = 1'b1;
            end
            oal_pkg::DP_RD_ADDR: begin
                ram_raddr = pos_a;
            end
            oal_pkg::DP_RD_CAP: begin
                n_item_out = ram_rdata;
                n_ok       = 1'b1;
            end
            oal_pkg::DP_CLEAR: begin
                n_cnt = '0;
                n_ok  = 1'b1;
            end
            oal_pkg::DP_FND_PRIME: begin
                n_ok      = 1'b1;
                n_idx     = '0;
                ram_raddr = '0;
            end
            oal_pkg::DP_FND_CMP: begin
                // Compare entry idx, prefetch idx+1
                if (match) begin
                    n_found = 1'b1;
                    n_fpos  = r_idx;
                end
                n_idx     = r_idx + AW'(1);
                ram_raddr = r_idx + AW'(1);
            end
            oal_pkg::DP_EMIT: begin
                n_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= oal_pkg::S_IDLE;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_pos      <= n_pos;
        r_item     <= n_item;
        r_dst      <= n_dst;
        r_append   <= n_append;
        r_idx      <= n_idx;
        r_ok       <= n_ok;
        r_found    <= n_found;
        r_fpos     <= n_fpos;
        r_item_out <= n_item_out;
    end

    // Result ports hold the working registers; o_done marks the valid cycle
    assign busy             = (r_pc != oal_pkg::S_IDLE);
    assign o_done           = r_done;
    assign o_ok             = r_ok;
    assign o_item_out       = item_out_x[oal_pkg::IN_ITEM_W-1:0];
    assign o_found          = r_found;
    assign o_found_position = fpos_x[oal_pkg::POSITION_W-1:0];
    assign o_entry_count    = cnt_x[oal_pkg::COUNT_OUT_W-1:0];

    // Checks
    `OAL_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, cnt_x <= CMP_W'(DEPTH), "count beyond depth")
    `OAL_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `OAL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "item not started")
    `OAL_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !busy, $stable(r_cnt), "count moved while idle")
    `OAL_ASSERT_SAME(a_found_ok, i_clk, i_rst_n, o_done && o_found, o_ok, "match without ok")

endmodule

`default_nettype wire

>>> sv/oal_ram.sv
// ----------------------------------------------------------------------------
// Ordered array list unit - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_ram #(
    parameter int WIDTH = oal_pkg::ITEM_WIDTH_DEF,
    parameter int DEPTH = oal_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> dv/tb_ordered_array_list_unit.sv
// ----------------------------------------------------------------------------
// Ordered array list unit - testbench
// Sends list commands (insert, update, delete, read, find, clear and the
// unused codes) through the start/busy handshake in bursts with random gaps.
// A local copy of the list predicts every answer that a directed row does not
// give itself; each o_done strobe is checked field by field against the oldest answer still due.
// ----------------------------------------------------------------------------

module tb_ordered_array_list_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH     = oal_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = LIST_DEPTH + 8;
    localparam int PLAN_ROWS      = 25;

    // Action codes the block leaves unused: they must answer ok=0 and change nothing
    localparam logic [oal_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [oal_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                            ok;
        logic [oal_pkg::IN_ITEM_W-1:0]   item_out;
        logic                            found;
        logic [oal_pkg::POSITION_W-1:0]  found_pos;
        logic [oal_pkg::COUNT_OUT_W-1:0] count;
    } t_result;

    // One line of the directed plan; reps repeats the row with item + rep
    typedef struct {
        logic [oal_pkg::ACTION_W-1:0]   act;
        logic [oal_pkg::POSITION_W-1:0] pos;
        logic                           at_end;
        logic [oal_pkg::IN_ITEM_W-1:0]  item;
        int                             reps;
        bit                             typed;
        t_result                        want;
    } t_row;

    localparam t_result NO_ANSWER = '0;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [oal_pkg::ACTION_W-1:0]    i_action;
    logic [oal_pkg::POSITION_W-1:0]  i_position;
    logic                            i_at_end;
    logic [oal_pkg::IN_ITEM_W-1:0]   i_item;
    logic                            o_done;
    logic                            o_ok;
    logic [oal_pkg::IN_ITEM_W-1:0]   o_item_out;
    logic                            o_found;
    logic [oal_pkg::POSITION_W-1:0]  o_found_position;
    logic [oal_pkg::COUNT_OUT_W-1:0] o_entry_count;

    // Shadow of the list, advanced in acceptance order
    logic [oal_pkg::IN_ITEM_W-1:0] list_entries [LIST_DEPTH];
    int                            list_count;
    t_result                       list_answers_due [$];

    // Typed answer of the directed row on offer, read by the monitor at acceptance
    bit      row_typed;
    t_result row_want;

    int items_taken;
    int answers_checked;
    int mismatch_count;
    int idle_cycles;
    int action_hits [8];
    int full_refusals;
    int deepest_fill;

    ordered_array_list_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_at_end         (i_at_end),
        .i_item           (i_item),
        .o_done           (o_done),
        .o_ok             (o_ok),
        .o_item_out       (o_item_out),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_row step_row(input logic [oal_pkg::ACTION_W-1:0] act,
                                      input logic [oal_pkg::POSITION_W-1:0] pos,
                                      input logic at_end,
                                      input logic [oal_pkg::IN_ITEM_W-1:0] item,
                                      input int reps, input bit typed, input t_result want);
        t_row r;
        r = '{act: act, pos: pos, at_end: at_end, item: item, reps: reps,
              typed: typed, want: want};
        return r;
    endfunction

    // Apply one command to the shadow list and work out the answer it must give
    function automatic t_result apply_to_list(input logic [oal_pkg::ACTION_W-1:0] act,
                                              input logic [oal_pkg::POSITION_W-1:0] pos,
                                              input logic at_end,
                                              input logic [oal_pkg::IN_ITEM_W-1:0] item);
        t_result ans;
        int      slot;
        int      k;
        ans = '0;
        case (act)
            oal_pkg::ACT_INSERT: begin
                if (list_count < LIST_DEPTH) begin
                    // past the end, or the end marker, appends
                    slot = (at_end || pos >= list_count) ? list_count : int'(pos);
                    for (k = list_count; k > slot; k--)
                        list_entries[k] = list_entries[k-1];
                    list_entries[slot] = item;
                    list_count++;
                    ans.ok = 1'b1;
                end
            end
            oal_pkg::ACT_UPDATE: begin
                if (pos < list_count) begin
                    list_entries[pos] = item;
                    ans.ok = 1'b1;
                end
            end
            oal_pkg::ACT_DELETE: begin
                if (pos < list_count) begin
                    for (k = pos; k + 1 < list_count; k++)
                        list_entries[k] = list_entries[k+1];
                    list_count--;
                    ans.ok = 1'b1;
                end
            end
            oal_pkg::ACT_READ: begin
                if (pos < list_count) begin
                    ans.item_out = list_entries[pos];
                    ans.ok = 1'b1;
                end
            end
            oal_pkg::ACT_FIND: begin
                // first match wins; no match still answers ok
                ans.ok = 1'b1;
                for (k = 0; k < list_count; k++) begin
                    if (!ans.found && list_entries[k] == item) begin
                        ans.found = 1'b1;
                        ans.found_pos = oal_pkg::POSITION_W'(k);
                    end
                end
            end
            oal_pkg::ACT_CLEAR: begin
                list_count = 0;
                ans.ok = 1'b1;
            end
            default: ;
        endcase
        ans.count = oal_pkg::COUNT_OUT_W'(list_count);
        return ans;
    endfunction

    task automatic note_mismatch(input string what,
                                 input logic [oal_pkg::IN_ITEM_W-1:0] got,
                                 input logic [oal_pkg::IN_ITEM_W-1:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check the answer shown first, then
    // take the new item, so a result and an acceptance on the same edge keep
    // their order in the queue.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_done) begin
                moved = 1'b1;
                answers_checked++;
                if (list_answers_due.size() == 0) begin
                    note_mismatch("result with no item outstanding", o_item_out, '0);
                end else begin
                    want = list_answers_due.pop_front();
                    if (o_ok !== want.ok)
                        note_mismatch("ok", o_ok, want.ok);
                    if (o_item_out !== want.item_out)
                        note_mismatch("item_out", o_item_out, want.item_out);
                    if (o_found !== want.found)
                        note_mismatch("found", o_found, want.found);
                    if (o_found_position !== want.found_pos)
                        note_mismatch("found_position", o_found_position, want.found_pos);
                    if (o_entry_count !== want.count)
                        note_mismatch("entry_count", o_entry_count, want.count);
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                items_taken++;
                action_hits[i_action]++;
                if (i_action == oal_pkg::ACT_INSERT && list_count == LIST_DEPTH)
                    full_refusals++;
                fresh = apply_to_list(i_action, i_position, i_at_end, i_item);
                // typed rows replace the prediction; the shadow still advances
                list_answers_due.push_back(row_typed ? row_want : fresh);
                if (list_count > deepest_fill)
                    deepest_fill = list_count;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles, %0d answers still due",
                         idle_cycles, list_answers_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [oal_pkg::IN_ITEM_W-1:0] item_pool [8];
    t_row                          plan [PLAN_ROWS];
    int                            burst_left;

    // Offer one item at the falling edge and hold it until taken. Between
    // bursts drop start for a random gap and scribble on the idle fields.
    task automatic offer_item(input logic [oal_pkg::ACTION_W-1:0] act,
                              input logic [oal_pkg::POSITION_W-1:0] pos,
                              input logic at_end,
                              input logic [oal_pkg::IN_ITEM_W-1:0] item,
                              input bit typed, input t_result want);
        int gap;
        int taken_before;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start      = 1'b0;
                i_action   = oal_pkg::ACTION_W'($urandom);
                i_position = oal_pkg::POSITION_W'($urandom);
                i_at_end   = 1'($urandom);
                i_item     = $urandom;
                repeat (gap) @(negedge i_clk);
            end
            // now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
        i_action   = act;
        i_position = pos;
        i_at_end   = at_end;
        i_item     = item;
        row_typed  = typed;
        row_want   = want;
        start      = 1'b1;
        taken_before = items_taken;
        do @(negedge i_clk); while (items_taken == taken_before);
        burst_left--;
    endtask

    initial begin
        int                             n;
        int                             rep;
        int                             r;
        int                             span;
        bit                             growing;
        logic [oal_pkg::ACTION_W-1:0]   act;
        logic [oal_pkg::POSITION_W-1:0] pos;
        logic                           at_end;
        logic [oal_pkg::IN_ITEM_W-1:0]  item;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_action   = '0;
        i_position = '0;
        i_at_end   = 1'b0;
        i_item     = '0;
        row_typed  = 1'b0;
        row_want   = NO_ANSWER;
        list_count = 0;
        items_taken = 0;
        answers_checked = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        full_refusals = 0;
        deepest_fill = 0;
        burst_left = 0;
        foreach (action_hits[j]) action_hits[j] = 0;
        foreach (list_entries[j]) list_entries[j] = '0;

        // A small pool of values, so duplicates and find hits are common
        item_pool[0] = '0;
        item_pool[1] = '1;
        for (n = 2; n < 8; n++) item_pool[n] = $urandom;

        // Directed plan, starting from the empty list after reset
        plan = '{
            step_row(oal_pkg::ACT_READ,   4'd0,  1'b0, 32'h0,        1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd0}),
            step_row(oal_pkg::ACT_DELETE, 4'd0,  1'b0, 32'h0,        1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd0}),
            step_row(oal_pkg::ACT_UPDATE, 4'd15, 1'b0, 32'hFFFFFFFF, 1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd0}),
            step_row(oal_pkg::ACT_FIND,   4'd0,  1'b0, 32'h0,        1, 1,
                     t_result'{1'b1, 32'h0, 1'b0, 4'd0, 5'd0}),
            step_row(oal_pkg::ACT_INSERT, 4'd15, 1'b0, 32'hFFFFFFFF, 1, 1,
                     t_result'{1'b1, 32'h0, 1'b0, 4'd0, 5'd1}),
            step_row(oal_pkg::ACT_INSERT, 4'd0,  1'b1, 32'h0,        1, 1,
                     t_result'{1'b1, 32'h0, 1'b0, 4'd0, 5'd2}),
            step_row(oal_pkg::ACT_INSERT, 4'd0,  1'b0, 32'h12345678, 1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_READ,   4'd0,  1'b0, 32'h0,        1, 1,
                     t_result'{1'b1, 32'h12345678, 1'b0, 4'd0, 5'd3}),
            step_row(oal_pkg::ACT_READ,   4'd1,  1'b0, 32'h0,        1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_FIND,   4'd0,  1'b0, 32'hFFFFFFFF, 1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_UPDATE, 4'd2,  1'b0, 32'hA5A5A5A5, 1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_READ,   4'd2,  1'b0, 32'h0,        1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_DELETE, 4'd0,  1'b0, 32'h0,        1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_READ,   4'd3,  1'b0, 32'h0,        1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd2}),
            step_row(ACT_SPARE_6,         4'd0,  1'b0, 32'h0,        1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd2}),
            step_row(ACT_SPARE_7,         4'd15, 1'b1, 32'hFFFFFFFF, 1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd2}),
            step_row(oal_pkg::ACT_CLEAR,  4'd0,  1'b0, 32'h0,        1, 1,
                     t_result'{1'b1, 32'h0, 1'b0, 4'd0, 5'd0}),
            // fill to the brim by appending
            step_row(oal_pkg::ACT_INSERT, 4'd0,  1'b1, 32'h5A000000, LIST_DEPTH, 0,
                     NO_ANSWER),
            step_row(oal_pkg::ACT_INSERT, 4'd0,  1'b0, 32'hDEADBEEF, 1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd16}),
            step_row(oal_pkg::ACT_FIND,   4'd0,  1'b0, 32'h5A00000F, 1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_READ,   4'd15, 1'b0, 32'h0,        1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_DELETE, 4'd15, 1'b0, 32'h0,        1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_DELETE, 4'd0,  1'b0, 32'h0,        1, 0, NO_ANSWER),
            step_row(oal_pkg::ACT_UPDATE, 4'd14, 1'b0, 32'h0,        1, 1,
                     t_result'{1'b0, 32'h0, 1'b0, 4'd0, 5'd14}),
            step_row(oal_pkg::ACT_FIND,   4'd0,  1'b0, 32'h5A000000, 1, 1,
                     t_result'{1'b1, 32'h0, 1'b0, 4'd0, 5'd14})
        };

        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[p]) begin
            for (rep = 0; rep < plan[p].reps; rep++)
                offer_item(plan[p].act, plan[p].pos, plan[p].at_end,
                           plan[p].item + rep, plan[p].typed, plan[p].want);
        end

        // Random part: swing between filling and draining so every fill level,
        // the full list and the empty list are visited many times.
        growing = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (list_count == 0)
                growing = 1'b1;
            else if (list_count == LIST_DEPTH && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if ($urandom_range(0, 99) < 3)
                growing = ~growing;

            r = $urandom_range(0, 99);
            if (growing)
                act = (r < 44) ? oal_pkg::ACT_INSERT :
                      (r < 54) ? oal_pkg::ACT_DELETE :
                      (r < 65) ? oal_pkg::ACT_UPDATE :
                      (r < 77) ? oal_pkg::ACT_READ   :
                      (r < 93) ? oal_pkg::ACT_FIND   :
                      (r < 95) ? oal_pkg::ACT_CLEAR  :
                      (r < 97) ? ACT_SPARE_6 : ACT_SPARE_7;
            else
                act = (r < 12) ? oal_pkg::ACT_INSERT :
                      (r < 52) ? oal_pkg::ACT_DELETE :
                      (r < 63) ? oal_pkg::ACT_UPDATE :
                      (r < 76) ? oal_pkg::ACT_READ   :
                      (r < 92) ? oal_pkg::ACT_FIND   :
                      (r < 94) ? oal_pkg::ACT_CLEAR  :
                      (r < 97) ? ACT_SPARE_6 : ACT_SPARE_7;

            // mostly a position inside the list, sometimes anywhere
            span = (act == oal_pkg::ACT_INSERT) ? list_count + 1 : list_count;
            if (span > LIST_DEPTH) span = LIST_DEPTH;
            if (span > 0 && $urandom_range(0, 9) < 8)
                pos = oal_pkg::POSITION_W'($urandom_range(0, span - 1));
            else
                pos = oal_pkg::POSITION_W'($urandom_range(0, 15));
            at_end = ($urandom_range(0, 6) == 0);

            r = $urandom_range(0, 9);
            if (act == oal_pkg::ACT_FIND && list_count > 0 && r < 5)
                item = list_entries[$urandom_range(0, list_count - 1)];
            else if (r < 6)
                item = item_pool[$urandom_range(0, 7)];
            else
                item = $urandom;

            offer_item(act, pos, at_end, item, 1'b0, NO_ANSWER);
        end

        // Drop start, let every answer come back, then allow a margin for strays
        start = 1'b0;
        while (list_answers_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d items: insert %0d, update %0d, delete %0d, read %0d,",
                 items_taken, action_hits[oal_pkg::ACT_INSERT],
                 action_hits[oal_pkg::ACT_UPDATE], action_hits[oal_pkg::ACT_DELETE],
                 action_hits[oal_pkg::ACT_READ]);
        $display("find %0d, clear %0d, unused %0d; %0d answers checked, %0d full refusals,",
                 action_hits[oal_pkg::ACT_FIND], action_hits[oal_pkg::ACT_CLEAR],
                 action_hits[ACT_SPARE_6] + action_hits[ACT_SPARE_7],
                 answers_checked, full_refusals);
        $display("deepest fill %0d, %0d mismatches", deepest_fill, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
